### rtl/core/tlpm_pkg.sv
// Shared types and constants for the two-level page map range allocator.
`default_nettype none

package tlpm_pkg;

    localparam logic [1:0]  MODE_FIND   = 2'd0;
    localparam logic [1:0]  MODE_COMMIT = 2'd1;
    localparam logic [1:0]  MODE_FREE   = 2'd2;

    localparam int          ENTRY_W     = 23;
    localparam int          E_PRESENT   = 0;
    localparam logic [9:0]  KFD_RESET   = 10'd768;
    localparam logic [31:0] FAIL_ADDR   = 32'h0BAD_C0DE;
    localparam logic [0:0]  REG_KFD     = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FDIR_RD,
        S_FDIR_EV,
        S_FPG_RD,
        S_FPG_EV,
        S_CDIR_RD,
        S_CDIR_EV,
        S_CPG,
        S_FRPG,
        S_FRDIR_RD,
        S_FRDIR_EV,
        S_FRCHK_RD,
        S_FRCHK_EV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [31:0] size_bytes;
        logic        writable;
        logic        user_access;
        logic [19:0] new_table_frame;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [31:0] result_addr;
        logic        table_taken;
        logic        table_released;
        logic [31:0] released_addr;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/core/tlpm_engine.sv
// Sequencer and entry memories of the page map allocator.
`default_nettype none

module tlpm_engine #(
    parameter int DIR_COUNT   = 1024,
    parameter int TABLE_COUNT = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire tlpm_pkg::t_req i_req,
    input  wire logic [9:0]    i_kfd,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output tlpm_pkg::t_rsp     o_rsp
);

    localparam int DW     = $clog2(DIR_COUNT);
    localparam int TW     = $clog2(TABLE_COUNT);
    localparam int PAW    = DW + TW;
    localparam int PDEPTH = DIR_COUNT << TW;

    logic [tlpm_pkg::ENTRY_W-1:0] dir_mem  [DIR_COUNT];
    logic [tlpm_pkg::ENTRY_W-1:0] page_mem [PDEPTH];
    logic [tlpm_pkg::ENTRY_W-1:0] r_dir_q, r_page_q;

    tlpm_pkg::t_state r_state, n_state;

    logic [PAW-1:0]  r_clr, n_clr;
    logic [DW-1:0]   r_d, n_d;
    logic [10:0]     r_tx, n_tx;
    logic [20:0]     r_cnt, n_cnt;
    logic [20:0]     r_left, n_left;
    logic [31:0]     r_start, n_start;
    logic [19:0]     r_frame, n_frame;
    logic [19:0]     r_nframe, n_nframe;
    logic            r_wr, n_wr;
    logic            r_usr, n_usr;
    tlpm_pkg::t_rsp  r_res, n_res;
    logic            r_out_valid, n_out_valid;
    tlpm_pkg::t_rsp  r_out, n_out;

    logic            dir_we, page_we;
    logic [DW-1:0]   dir_waddr, dir_raddr;
    logic [PAW-1:0]  page_waddr, page_raddr;
    logic [tlpm_pkg::ENTRY_W-1:0] dir_wdata, page_wdata;

    logic [32:0]     psum;
    logic [20:0]     req_pages;
    logic [9:0]      req_d10;
    logic [9:0]      req_t10;
    logic            req_d_ok;
    logic            run_on;
    logic            tx_last;
    logic            d_last;
    logic [20:0]     cnt_inc;
    logic [31:0]     cur_addr;

    assign psum      = {1'b0, i_req.size_bytes} + 33'd4095;
    assign req_pages = psum[32:12];
    assign req_d10   = i_req.virt_addr[31:22];
    assign req_t10   = i_req.virt_addr[21:12];
    assign req_d_ok  = {1'b0, req_d10} < 11'(DIR_COUNT);
    assign run_on    = (r_left != 21'd0) && (r_tx < 11'(TABLE_COUNT));
    assign tx_last   = r_tx == 11'(TABLE_COUNT - 1);
    assign d_last    = r_d == DW'(DIR_COUNT - 1);
    assign cnt_inc   = r_cnt + 21'd1;
    assign cur_addr  = {10'(r_d), r_tx[9:0], 12'd0};

    assign o_req_ready = r_state == tlpm_pkg::S_IDLE;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // memories: one write and one registered read port each
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        r_dir_q <= dir_mem[dir_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            page_mem[page_waddr] <= page_wdata;
        end
        r_page_q <= page_mem[page_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlpm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_tx     <= n_tx;
        r_cnt    <= n_cnt;
        r_left   <= n_left;
        r_start  <= n_start;
        r_frame  <= n_frame;
        r_nframe <= n_nframe;
        r_wr     <= n_wr;
        r_usr    <= n_usr;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // next state and working registers
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_d         = r_d;
        n_tx        = r_tx;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_start     = r_start;
        n_frame     = r_frame;
        n_nframe    = r_nframe;
        n_wr        = r_wr;
        n_usr       = r_usr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tlpm_pkg::S_CLEAR: begin
                n_clr = r_clr + PAW'(1);
                if (r_clr == PAW'(PDEPTH - 1)) begin
                    n_state = tlpm_pkg::S_IDLE;
                end
            end
            tlpm_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_res    = '0;
                    n_d      = req_d10[DW-1:0];
                    n_tx     = {1'b0, req_t10};
                    n_left   = req_pages;
                    n_frame  = i_req.phys_addr[31:12];
                    n_nframe = i_req.new_table_frame;
                    n_wr     = i_req.writable;
                    n_usr    = i_req.user_access;
                    n_cnt    = '0;
                    case (i_req.mode)
                        tlpm_pkg::MODE_FIND: begin
                            if ({1'b0, i_kfd} < 11'(DIR_COUNT)) begin
                                n_d     = i_kfd[DW-1:0];
                                n_state = tlpm_pkg::S_FDIR_RD;
                            end else begin
                                n_res.status      = 1'b1;
                                n_res.result_addr = tlpm_pkg::FAIL_ADDR;
                                n_state           = tlpm_pkg::S_RESP;
                            end
                        end
                        tlpm_pkg::MODE_COMMIT: begin
                            n_res.result_addr = i_req.virt_addr;
                            n_state = req_d_ok ? tlpm_pkg::S_CDIR_RD : tlpm_pkg::S_RESP;
                        end
                        tlpm_pkg::MODE_FREE: begin
                            n_state = req_d_ok ? tlpm_pkg::S_FRPG : tlpm_pkg::S_RESP;
                        end
                        default: begin
                            n_state = tlpm_pkg::S_RESP;
                        end
                    endcase
                end
            end
            tlpm_pkg::S_FDIR_RD: begin
                n_state = tlpm_pkg::S_FDIR_EV;
            end
            tlpm_pkg::S_FDIR_EV: begin
                if (!r_dir_q[tlpm_pkg::E_PRESENT]) begin
                    n_res.result_addr = {10'(r_d), 22'd0};
                    n_state           = tlpm_pkg::S_RESP;
                end else begin
                    n_tx    = '0;
                    n_state = tlpm_pkg::S_FPG_RD;
                end
            end
            tlpm_pkg::S_FPG_RD: begin
                n_state = tlpm_pkg::S_FPG_EV;
            end
            tlpm_pkg::S_FPG_EV: begin
                n_state = tlpm_pkg::S_FPG_RD;
                n_tx    = r_tx + 11'd1;
                if (r_page_q[tlpm_pkg::E_PRESENT]) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = cnt_inc;
                    if (r_cnt == 21'd0) begin
                        n_start = cur_addr;
                    end
                end
                if (!r_page_q[tlpm_pkg::E_PRESENT] && cnt_inc >= r_left) begin
                    n_res.result_addr = (r_cnt == 21'd0) ? cur_addr : r_start;
                    n_state           = tlpm_pkg::S_RESP;
                end else if (tx_last) begin
                    if (d_last) begin
                        n_res.status      = 1'b1;
                        n_res.result_addr = tlpm_pkg::FAIL_ADDR;
                        n_state           = tlpm_pkg::S_RESP;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_state = tlpm_pkg::S_FDIR_RD;
                    end
                end
            end
            tlpm_pkg::S_CDIR_RD: begin
                n_state = tlpm_pkg::S_CDIR_EV;
            end
            tlpm_pkg::S_CDIR_EV: begin
                if (!r_dir_q[tlpm_pkg::E_PRESENT]) begin
                    n_res.table_taken = 1'b1;
                end
                n_state = tlpm_pkg::S_CPG;
            end
            tlpm_pkg::S_CPG: begin
                if (run_on) begin
                    n_tx    = r_tx + 11'd1;
                    n_left  = r_left - 21'd1;
                    n_frame = r_frame + 20'd1;
                end else begin
                    n_state = tlpm_pkg::S_RESP;
                end
            end
            tlpm_pkg::S_FRPG: begin
                if (run_on) begin
                    n_tx   = r_tx + 11'd1;
                    n_left = r_left - 21'd1;
                end else begin
                    n_state = tlpm_pkg::S_FRDIR_RD;
                end
            end
            tlpm_pkg::S_FRDIR_RD: begin
                n_state = tlpm_pkg::S_FRDIR_EV;
            end
            tlpm_pkg::S_FRDIR_EV: begin
                if (r_dir_q[tlpm_pkg::E_PRESENT]) begin
                    n_tx    = '0;
                    n_frame = r_dir_q[22:3];
                    n_state = tlpm_pkg::S_FRCHK_RD;
                end else begin
                    n_state = tlpm_pkg::S_RESP;
                end
            end
            tlpm_pkg::S_FRCHK_RD: begin
                n_state = tlpm_pkg::S_FRCHK_EV;
            end
            tlpm_pkg::S_FRCHK_EV: begin
                if (r_page_q[tlpm_pkg::E_PRESENT]) begin
                    n_state = tlpm_pkg::S_RESP;
                end else if (tx_last) begin
                    n_res.table_released = 1'b1;
                    n_res.released_addr  = {r_frame, 12'd0};
                    n_state              = tlpm_pkg::S_RESP;
                end else begin
                    n_tx    = r_tx + 11'd1;
                    n_state = tlpm_pkg::S_FRCHK_RD;
                end
            end
            tlpm_pkg::S_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = tlpm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlpm_pkg::S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb begin
        dir_we     = 1'b0;
        dir_waddr  = r_d;
        dir_wdata  = '0;
        dir_raddr  = r_d;
        page_we    = 1'b0;
        page_waddr = {r_d, r_tx[TW-1:0]};
        page_wdata = '0;
        page_raddr = {r_d, r_tx[TW-1:0]};

        case (r_state)
            tlpm_pkg::S_CLEAR: begin
                page_we    = 1'b1;
                page_waddr = r_clr;
                dir_we     = r_clr < PAW'(DIR_COUNT);
                dir_waddr  = r_clr[DW-1:0];
            end
            tlpm_pkg::S_CDIR_EV: begin
                dir_we    = !r_dir_q[tlpm_pkg::E_PRESENT];
                dir_wdata = {r_nframe, r_usr, 1'b1, 1'b1};
            end
            tlpm_pkg::S_CPG: begin
                page_we    = run_on;
                page_wdata = {r_frame, r_usr, r_wr, 1'b1};
            end
            tlpm_pkg::S_FRPG: begin
                page_we = run_on;
            end
            tlpm_pkg::S_FRCHK_EV: begin
                dir_we = !r_page_q[tlpm_pkg::E_PRESENT] && tx_last;
            end
            default: begin
                dir_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/two_level_page_map_range_allocator_unit.sv
// Top level of the two-level page map range allocator.
//
// One request transaction enters on the s_axis channel (find, commit or free) and
// exactly one response transaction leaves on m_axis. Requests are handled one at a
// time; s_axis_tready is high only while the sequencer is idle.
// Find reads the directory entries from kernel_first_dir on and scans the page
// entries of each present table; commit reads the directory entry and then writes
// the pages; free clears the pages and then reads the table's entries to check
// it for emptiness. Each entry memory has a single read port.
// The response sits in an output register, so a stalled receiver holds only that
// transaction; the next request is still taken and worked on, and waits for the
// register to drain before its own response is posted.
// After reset both memories are cleared, one entry per cycle, across all
// DIR_COUNT * 2**clog2(TABLE_COUNT) page entries; s_axis_tready is low meanwhile.
// kernel_first_dir sits on the APB port at address 0 and resets to 768.
`default_nettype none

module two_level_page_map_range_allocator_unit #(
    parameter int DIR_COUNT   = 1024,
    parameter int TABLE_COUNT = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // virt_addr, phys_addr, size_bytes, writable, user_access, new_table_frame, pad
    input  wire logic [119:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_addr, table_taken, table_released, released_addr, pad
    output logic [71:0]       m_axis_tdata,
    // status
    output logic [0:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [9:0]     r_kfd;
    tlpm_pkg::t_req req;
    tlpm_pkg::t_rsp rsp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tlpm_pkg::REG_KFD) ? {22'd0, r_kfd} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kfd <= tlpm_pkg::KFD_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == tlpm_pkg::REG_KFD) begin
            r_kfd <= pwdata[9:0];
        end
    end

    assign req.mode            = s_axis_tuser;
    assign req.virt_addr       = s_axis_tdata[31:0];
    assign req.phys_addr       = s_axis_tdata[63:32];
    assign req.size_bytes      = s_axis_tdata[95:64];
    assign req.writable        = s_axis_tdata[96];
    assign req.user_access     = s_axis_tdata[97];
    assign req.new_table_frame = s_axis_tdata[117:98];

    tlpm_engine #(
        .DIR_COUNT   (DIR_COUNT),
        .TABLE_COUNT (TABLE_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .i_kfd       (r_kfd),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_rsp       (rsp)
    );

    assign m_axis_tuser = rsp.status;
    assign m_axis_tdata = {6'd0, rsp.released_addr, rsp.table_released,
                           rsp.table_taken, rsp.result_addr};

endmodule

`default_nettype wire

### verif/tb_two_level_page_map_range_allocator_unit.sv
// Self-checking testbench for the two-level page map range allocator unit.
`default_nettype none

module tb_two_level_page_map_range_allocator_unit;

    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int NDIR = 1024;
    localparam int NTBL = 1024;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    two_level_page_map_range_allocator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow page map
    bit [22:0] dir_map [NDIR];
    bit [22:0] pg_map  [NDIR*NTBL];
    int        pg_live [NDIR];
    bit [9:0]  first_dir;

    tlpm_pkg::t_rsp rsp_q [$];
    int   errors;
    int   cycles;
    int   hold_left;
    bit   s_noidle, m_noidle;
    int   n_find, n_commit, n_free, n_fail, n_taken, n_rel;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic tlpm_pkg::t_rsp find_range(logic [31:0] size);
        tlpm_pkg::t_rsp r;
        logic [63:0] run;
        logic [31:0] start;
        r = '0;
        run = 0;
        start = 0;
        for (int d = int'(first_dir); d < NDIR; d++) begin
            if (!dir_map[d][tlpm_pkg::E_PRESENT]) begin
                r.result_addr = 32'(d) << 22;
                return r;
            end
            for (int t = 0; t < NTBL; t++) begin
                if (pg_map[d*NTBL+t][tlpm_pkg::E_PRESENT]) begin
                    run = 0;
                end else begin
                    if (run == 0) start = (32'(d) << 22) | (32'(t) << 12);
                    run++;
                    if (run * 4096 >= {32'd0, size}) begin
                        r.result_addr = start;
                        return r;
                    end
                end
            end
        end
        r.status = 1'b1;
        r.result_addr = tlpm_pkg::FAIL_ADDR;
        return r;
    endfunction

    function automatic tlpm_pkg::t_rsp map_update(tlpm_pkg::t_req q);
        tlpm_pkg::t_rsp r;
        int          d, t;
        logic [32:0] pages;
        logic [31:0] pa;
        r = '0;
        d = int'(q.virt_addr[31:22]);
        t = int'(q.virt_addr[21:12]);
        pages = ({1'b0, q.size_bytes} + 33'd4095) >> 12;
        case (q.mode)
            tlpm_pkg::MODE_FIND: r = find_range(q.size_bytes);
            tlpm_pkg::MODE_COMMIT: begin
                r.result_addr = q.virt_addr;
                if (!dir_map[d][tlpm_pkg::E_PRESENT]) begin
                    dir_map[d] = {q.new_table_frame, q.user_access, 1'b1, 1'b1};
                    r.table_taken = 1'b1;
                end
                for (int i = 0; i < pages && t + i < NTBL; i++) begin
                    pa = q.phys_addr + 32'(i) * 32'd4096;
                    if (!pg_map[d*NTBL+t+i][tlpm_pkg::E_PRESENT]) pg_live[d]++;
                    pg_map[d*NTBL+t+i] = {pa[31:12], q.user_access, q.writable, 1'b1};
                end
            end
            tlpm_pkg::MODE_FREE: begin
                for (int i = 0; i < pages && t + i < NTBL; i++) begin
                    if (pg_map[d*NTBL+t+i][tlpm_pkg::E_PRESENT]) pg_live[d]--;
                    pg_map[d*NTBL+t+i] = '0;
                end
                if (dir_map[d][tlpm_pkg::E_PRESENT] && pg_live[d] == 0) begin
                    r.table_released = 1'b1;
                    r.released_addr = {dir_map[d][22:3], 12'd0};
                    dir_map[d] = '0;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic send_req(tlpm_pkg::t_req q);
        @(negedge i_clk);
        if (!s_noidle && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.mode;
        s_axis_tdata  <= {2'b0, q.new_table_frame, q.user_access, q.writable,
                          q.size_bytes, q.phys_addr, q.virt_addr};
        do @(posedge i_clk); while (!s_axis_tready);
        rsp_q.push_back(map_update(q));
        case (q.mode)
            tlpm_pkg::MODE_FIND:   n_find++;
            tlpm_pkg::MODE_COMMIT: n_commit++;
            tlpm_pkg::MODE_FREE:   n_free++;
            default: ;
        endcase
    endtask

    task automatic req(logic [1:0] m, logic [31:0] va, logic [31:0] sz,
                       logic [31:0] pa = $urandom, logic [19:0] fr = $urandom);
        tlpm_pkg::t_req q;
        q.mode = m;
        q.virt_addr = va;
        q.phys_addr = pa;
        q.size_bytes = sz;
        q.writable = $urandom_range(0, 1);
        q.user_access = $urandom_range(0, 1);
        q.new_table_frame = fr;
        send_req(q);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [31:0] val);
        drain();
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * tlpm_pkg::REG_KFD); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        first_dir = val[9:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (m_noidle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        tlpm_pkg::t_rsp exp_r, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser[0];
            got.result_addr = m_axis_tdata[31:0];
            got.table_taken = m_axis_tdata[32];
            got.table_released = m_axis_tdata[33];
            got.released_addr = m_axis_tdata[65:34];
            if (rsp_q.size() == 0) begin
                if (errors < 10) $display("unexpected response transaction %h", got);
                errors++;
            end else begin
                exp_r = rsp_q.pop_front();
                n_fail += exp_r.status;
                n_taken += exp_r.table_taken;
                n_rel += exp_r.table_released;
                if (got !== exp_r) begin
                    if (errors < 10)
                        $display({"mismatch: exp st=%b ra=%h tk=%b rl=%b rla=%h",
                                  " got st=%b ra=%h tk=%b rl=%b rla=%h"},
                                 exp_r.status, exp_r.result_addr, exp_r.table_taken,
                                 exp_r.table_released, exp_r.released_addr,
                                 got.status, got.result_addr, got.table_taken,
                                 got.table_released, got.released_addr);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_va(int span);
        int d;
        d = first_dir + $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, NDIR - 1);
        if (d > NDIR - 1) d = NDIR - 1;
        return {10'(d), 10'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 1023 : 40)),
                12'($urandom)};
    endfunction

    function automatic logic [31:0] pick_size();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return $urandom_range(0, 8 * 4096);
        if (k < 9) return $urandom_range(0, 1024 * 4096);
        return $urandom;
    endfunction

    task automatic test_directed();
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'h0);
        req(tlpm_pkg::MODE_COMMIT, 32'hC000_0000, 32'h0, 32'h0, 20'hFFFFF);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'h0);
        req(tlpm_pkg::MODE_COMMIT, 32'hC000_0000, 32'd1, 32'hFFFF_FFFF, 20'h0);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'd4096);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'hFFFF_FFFF);
        req(tlpm_pkg::MODE_COMMIT, 32'hC03F_C000, 32'd16 * 4096, 32'hFFFF_F000);
        req(tlpm_pkg::MODE_COMMIT, 32'hC000_3000, 32'd2 * 4096 + 1, 32'hFFFF_E000);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'd3 * 4096);
        req(tlpm_pkg::MODE_FREE, 32'hC000_0000, 32'd1);
        req(tlpm_pkg::MODE_FREE, 32'h8000_0000, 32'd4096);
        req(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
        req(tlpm_pkg::MODE_FREE, 32'hC000_3000, 32'd5 * 4096);
        req(tlpm_pkg::MODE_FREE, 32'hC03F_C000, 32'hFFFF_FFFF);
        req(tlpm_pkg::MODE_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5000);
        req(tlpm_pkg::MODE_FREE, 32'hFFC0_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_find_fail();
        apb_write(32'd1023);
        req(tlpm_pkg::MODE_COMMIT, 32'hFFC0_0000, 32'd4096);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'hFFFF_FFFF);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'd4096);
        req(tlpm_pkg::MODE_FREE, 32'hFFC0_0000, 32'd4096);
        apb_write(32'd0);
        req(tlpm_pkg::MODE_FIND, 32'h0, 32'd0);
    endtask

    task automatic test_random(int n, logic [9:0] kfd);
        int k;
        apb_write({22'($urandom), kfd});
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 30) req(tlpm_pkg::MODE_FIND, $urandom, pick_size());
            else if (k < 65) req(tlpm_pkg::MODE_COMMIT, pick_va(3), pick_size());
            else if (k < 95) req(tlpm_pkg::MODE_FREE, pick_va(3), pick_size());
            else req(MODE_UNUSED, $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        drain();
        s_noidle = 1;
        hold_left = 400;
        for (int i = 0; i < 8; i++)
            req(tlpm_pkg::MODE_COMMIT, pick_va(1), $urandom_range(0, 4096));
        s_noidle = 0;
    endtask

    initial begin
        errors = 0; cycles = 0; hold_left = 0; s_noidle = 0; m_noidle = 0;
        first_dir = tlpm_pkg::KFD_RESET;
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_find_fail();
        test_random(80, 10'd768);
        test_backpressure();
        s_noidle = 1; m_noidle = 1;
        test_random(55, 10'd0);
        s_noidle = 0; m_noidle = 0;
        test_random(60, 10'd1023);
        test_random(65, 10'($urandom));
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d find, %0d commit, %0d free transactions",
                 n_find, n_commit, n_free);
        $display("%0d finds failed, %0d tables taken, %0d released, %0d mismatches",
                 n_fail, n_taken, n_rel, errors);
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
